// ===== rtl/stepper_mission_ring_queue_assert.svh =====
// Assertion macros for the stepper mission ring queue.
// Used by the top level only; the clock and reset names are those of its ports.
`ifndef STEPPER_MISSION_RING_QUEUE_ASSERT_SVH
`define STEPPER_MISSION_RING_QUEUE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define SMRQ_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
   else $error(msg);

// Next-cycle implication, checked outside reset
`define SMRQ_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
   else $error(msg);

`endif

// ===== rtl/smrq_pkg.sv =====
// Shared types, codes and tables for the stepper mission ring queue.
// No dependencies; imported by the front, back and top level.
`default_nettype none

package smrq_pkg;

   localparam int KIND_W    = 4;
   localparam int WORD_W    = 16;
   localparam int STEP_W    = 2;
   localparam int SPEED_W   = 3;
   localparam int RATE_W    = 8;
   localparam int INDEX_W   = 8;
   localparam int SLOTOUT_W = 3;
   localparam int LENOUT_W  = 9;
   localparam int PULSE_W   = 7;

   // Request kinds as they arrive on the port
   localparam logic [KIND_W-1:0] KIND_OPEN  = 4'd0;
   localparam logic [KIND_W-1:0] KIND_WORD  = 4'd1;
   localparam logic [KIND_W-1:0] KIND_STEP  = 4'd2;
   localparam logic [KIND_W-1:0] KIND_SPEED = 4'd3;
   localparam logic [KIND_W-1:0] KIND_RATE  = 4'd4;
   localparam logic [KIND_W-1:0] KIND_CLOSE = 4'd5;
   localparam logic [KIND_W-1:0] KIND_FETCH = 4'd6;
   localparam logic [KIND_W-1:0] KIND_READ  = 4'd7;
   localparam logic [KIND_W-1:0] KIND_DONE  = 4'd8;

   // Step direction codes
   localparam logic [STEP_W-1:0] STEP_FWD  = 2'd1;
   localparam logic [STEP_W-1:0] STEP_BACK = 2'd2;

   // Capture-mode words
   localparam logic [WORD_W-1:0] WORD_FWD   = 16'h4878;
   localparam logic [WORD_W-1:0] WORD_BACK  = 16'h5878;
   localparam logic [WORD_W-1:0] WORD_IDLE  = 16'h4848;
   localparam logic [WORD_W-1:0] HIGH_MASK  = 16'hFF00;
   localparam logic [WORD_W-1:0] LOW_IDLE   = 16'h0048;

   localparam logic [SPEED_W-1:0] NUM_SPEEDS  = 3'd5;
   localparam logic [PULSE_W-1:0] PULSE_RESET = 7'd10;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_REJ = 1'b1;

   typedef enum logic [3:0] {
      OP_OPEN,
      OP_WORD,
      OP_STEP,
      OP_SPEED,
      OP_RATE,
      OP_CLOSE,
      OP_FETCH,
      OP_READ,
      OP_DONE,
      OP_BAD
   } op_code_type;

   // Classified request as it sits in the queue
   typedef struct packed {
      op_code_type          op;
      logic [WORD_W-1:0]    data_word;
      logic [STEP_W-1:0]    step_x;
      logic [STEP_W-1:0]    step_y;
      logic [SPEED_W-1:0]   speed_code;
      logic [RATE_W-1:0]    update_rate;
      logic [INDEX_W-1:0]   word_index;
   } op_type;

   // Result payload
   typedef struct packed {
      logic                 status;
      logic [SLOTOUT_W-1:0] slot;
      logic [WORD_W-1:0]    read_word;
      logic [SPEED_W-1:0]   mission_speed;
      logic [RATE_W-1:0]    mission_rate;
      logic [LENOUT_W-1:0]  mission_length;
      logic [WORD_W-1:0]    timer_period;
      logic [WORD_W-1:0]    direction_compare;
      logic [WORD_W-1:0]    step_compare;
   } rsp_type;

   // Step code to capture-mode word; others keep the last high byte
   function automatic logic [WORD_W-1:0] encode_step(input logic [STEP_W-1:0] code,
                                                     input logic [WORD_W-1:0] last);
      logic [WORD_W-1:0] w;
      case (code)
         STEP_FWD:  w = WORD_FWD;
         STEP_BACK: w = WORD_BACK;
         default:   w = (last & HIGH_MASK) | LOW_IDLE;
      endcase
      return w;
   endfunction

   // Timer reload per speed code
   function automatic logic [WORD_W-1:0] period_of(input logic [SPEED_W-1:0] sp);
      logic [WORD_W-1:0] p;
      case (sp)
         3'd0:    p = 16'd10000;
         3'd1:    p = 16'd5000;
         3'd2:    p = 16'd1000;
         3'd3:    p = 16'd500;
         3'd4:    p = 16'd100;
         default: p = '0;
      endcase
      return p;
   endfunction

   // Half period per speed code
   function automatic logic [WORD_W-1:0] half_of(input logic [SPEED_W-1:0] sp);
      logic [WORD_W-1:0] h;
      case (sp)
         3'd0:    h = 16'd5000;
         3'd1:    h = 16'd2500;
         3'd2:    h = 16'd500;
         3'd3:    h = 16'd250;
         3'd4:    h = 16'd50;
         default: h = '0;
      endcase
      return h;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/smrq_front.sv =====
// Front end: accepts requests, classifies the kind and holds them in a
// two-entry queue for the back end. Depends on smrq_pkg.
`default_nettype none

module smrq_front
   import smrq_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [KIND_W-1:0]    req_kind,
   input  wire logic [WORD_W-1:0]    req_data_word,
   input  wire logic [STEP_W-1:0]    req_step_x,
   input  wire logic [STEP_W-1:0]    req_step_y,
   input  wire logic [SPEED_W-1:0]   req_speed_code,
   input  wire logic [RATE_W-1:0]    req_update_rate,
   input  wire logic [INDEX_W-1:0]   req_word_index,
   output logic                      q_valid,
   output op_type                    q_op,
   input  wire logic                 q_take
);

   op_type       op_in;
   op_type       entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push;

   // Classify the kind
   always_comb begin
      op_in.data_word   = req_data_word;
      op_in.step_x      = req_step_x;
      op_in.step_y      = req_step_y;
      op_in.speed_code  = req_speed_code;
      op_in.update_rate = req_update_rate;
      op_in.word_index  = req_word_index;
      case (req_kind)
         KIND_OPEN:  op_in.op = OP_OPEN;
         KIND_WORD:  op_in.op = OP_WORD;
         KIND_STEP:  op_in.op = OP_STEP;
         KIND_SPEED: op_in.op = OP_SPEED;
         KIND_RATE:  op_in.op = OP_RATE;
         KIND_CLOSE: op_in.op = OP_CLOSE;
         KIND_FETCH: op_in.op = OP_FETCH;
         KIND_READ:  op_in.op = OP_READ;
         KIND_DONE:  op_in.op = OP_DONE;
         default:    op_in.op = OP_BAD;
      endcase
   end

   // Queue pointers and fill level
   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid & req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_op      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push   ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_take ? ~rd_ptr_ff : rd_ptr_ff;
      case ({push, q_take})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= op_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/smrq_back.sv =====
// Back end: ring pointers, mission word memory, slot descriptor memory,
// timer values and the result register. Depends on smrq_pkg.
`default_nettype none

module smrq_back
   import smrq_pkg::*;
#(
   parameter int NUM_SLOTS  = 8,
   parameter int SLOT_WORDS = 256
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [PULSE_W-1:0]   csr_wdata,
   input  wire logic                 q_valid,
   input  wire op_type               q_op,
   output logic                      q_take,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp
);

   localparam int SLOT_W  = $clog2(NUM_SLOTS);
   localparam int WORD_AW = $clog2(SLOT_WORDS);
   localparam int LEN_W   = $clog2(SLOT_WORDS + 1);
   localparam int CMP_W   = (LEN_W > INDEX_W) ? LEN_W : INDEX_W;
   localparam int ADDR_W  = SLOT_W + WORD_AW;
   localparam int DEPTH   = NUM_SLOTS * (2 ** WORD_AW);
   localparam int META_W  = SPEED_W + RATE_W + LEN_W;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
   localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(SLOT_WORDS);
   localparam logic [LEN_W-1:0]  LEN_PAIR  = LEN_W'(SLOT_WORDS - 2);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_STEP  = 4'b0010,
      S_FETCH = 4'b0100,
      S_READ  = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [SLOT_W-1:0]   write_slot_ff, write_slot_in;
   logic [SLOT_W-1:0]   read_slot_ff, read_slot_in;
   logic                write_open_ff, write_open_in;
   logic                read_open_ff, read_open_in;
   logic [LEN_W-1:0]    wr_len_ff, wr_len_in;
   logic [SPEED_W-1:0]  wr_speed_ff, wr_speed_in;
   logic [RATE_W-1:0]   wr_rate_ff, wr_rate_in;
   logic [LEN_W-1:0]    rd_len_ff, rd_len_in;
   logic [WORD_W-1:0]   last_x_ff, last_x_in;
   logic [WORD_W-1:0]   last_y_ff, last_y_in;
   logic [WORD_W-1:0]   pend_y_ff, pend_y_in;
   logic [WORD_W-1:0]   period_ff, period_in;
   logic [WORD_W-1:0]   half_ff, half_in;
   logic [PULSE_W-1:0]  pulse_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic [WORD_W-1:0]   word_mem [DEPTH];
   logic                wm_we;
   logic [ADDR_W-1:0]   wm_waddr;
   logic [WORD_W-1:0]   wm_wdata;
   logic [ADDR_W-1:0]   wm_raddr;
   logic [WORD_W-1:0]   wm_rdata_ff;

   logic [META_W-1:0]   meta_mem [NUM_SLOTS];
   logic                mm_we;
   logic [META_W-1:0]   mm_rdata_ff;

   logic [SLOT_W-1:0]   wr_nx;
   logic [SLOT_W-1:0]   rd_nx;
   logic                out_free;
   logic [WORD_W-1:0]   x_word;
   logic [WORD_W-1:0]   y_word;
   logic [SPEED_W-1:0]  f_speed;
   logic [RATE_W-1:0]   f_rate;
   logic [LEN_W-1:0]    f_len;
   logic [WORD_W-1:0]   f_period;
   logic [WORD_W-1:0]   f_half;

   // Ring successor of each pointer
   assign wr_nx    = (write_slot_ff == LAST_SLOT) ? '0 : write_slot_ff + 1'b1;
   assign rd_nx    = (read_slot_ff == LAST_SLOT) ? '0 : read_slot_ff + 1'b1;
   assign out_free = ~rsp_valid_ff | rsp_ready;

   // Step words and fetched descriptor
   assign x_word = encode_step(q_op.step_x, last_x_ff);
   assign y_word = encode_step(q_op.step_y, last_y_ff);
   assign {f_speed, f_rate, f_len} = mm_rdata_ff;
   assign f_period = (f_speed < NUM_SPEEDS) ? period_of(f_speed) : period_ff;
   assign f_half   = (f_speed < NUM_SPEEDS) ? half_of(f_speed) : half_ff;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      write_slot_in = write_slot_ff;
      read_slot_in  = read_slot_ff;
      write_open_in = write_open_ff;
      read_open_in  = read_open_ff;
      wr_len_in     = wr_len_ff;
      wr_speed_in   = wr_speed_ff;
      wr_rate_in    = wr_rate_ff;
      rd_len_in     = rd_len_ff;
      last_x_in     = last_x_ff;
      last_y_in     = last_y_ff;
      pend_y_in     = pend_y_ff;
      period_in     = period_ff;
      half_in       = half_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_in        = rsp_ff;
      q_take        = 1'b0;
      wm_we         = 1'b0;
      wm_waddr      = {write_slot_ff, WORD_AW'(wr_len_ff)};
      wm_wdata      = q_op.data_word;
      wm_raddr      = {read_slot_ff, WORD_AW'(q_op.word_index)};
      mm_we         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (q_valid && out_free) begin
               q_take        = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_in        = '0;
               rsp_in.status = STATUS_REJ;
               case (q_op.op)
                  OP_OPEN: begin
                     if (!write_open_ff && wr_nx != read_slot_ff) begin
                        write_slot_in = wr_nx;
                        write_open_in = 1'b1;
                        wr_len_in     = '0;
                        wr_speed_in   = '0;
                        wr_rate_in    = '0;
                        rsp_in.slot   = SLOTOUT_W'(wr_nx);
                        rsp_in.status = STATUS_OK;
                     end
                  end
                  OP_WORD: begin
                     if (write_open_ff && wr_len_ff < LEN_MAX) begin
                        wm_we         = 1'b1;
                        wr_len_in     = wr_len_ff + 1'b1;
                        rsp_in.status = STATUS_OK;
                     end
                  end
                  OP_STEP: begin
                     // x word now, y word in the next cycle
                     if (write_open_ff && wr_len_ff <= LEN_PAIR) begin
                        wm_we         = 1'b1;
                        wm_wdata      = x_word;
                        wr_len_in     = wr_len_ff + 1'b1;
                        last_x_in     = x_word;
                        last_y_in     = y_word;
                        pend_y_in     = y_word;
                        state_in      = S_STEP;
                        rsp_in.status = STATUS_OK;
                     end
                  end
                  OP_SPEED: begin
                     if (write_open_ff) begin
                        wr_speed_in   = q_op.speed_code;
                        rsp_in.status = STATUS_OK;
                     end
                  end
                  OP_RATE: begin
                     if (write_open_ff) begin
                        wr_rate_in    = q_op.update_rate;
                        rsp_in.status = STATUS_OK;
                     end
                  end
                  OP_CLOSE: begin
                     // descriptor goes to the slot table on close
                     if (write_open_ff) begin
                        mm_we         = 1'b1;
                        write_open_in = 1'b0;
                        rsp_in.status = STATUS_OK;
                     end
                  end
                  OP_FETCH: begin
                     if (!read_open_ff && read_slot_ff != write_slot_ff &&
                         !(rd_nx == write_slot_ff && write_open_ff)) begin
                        read_slot_in = rd_nx;
                        read_open_in = 1'b1;
                        rsp_valid_in = 1'b0;
                        state_in     = S_FETCH;
                     end
                  end
                  OP_READ: begin
                     if (read_open_ff &&
                         CMP_W'(q_op.word_index) < CMP_W'(rd_len_ff)) begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_READ;
                     end
                  end
                  OP_DONE: begin
                     if (read_open_ff) begin
                        read_open_in  = 1'b0;
                        rsp_in.status = STATUS_OK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_STEP: begin
            wm_we     = 1'b1;
            wm_wdata  = pend_y_ff;
            wr_len_in = wr_len_ff + 1'b1;
            state_in  = S_IDLE;
         end
         S_FETCH: begin
            // unknown speeds keep the previous timing
            period_in                = f_period;
            half_in                  = f_half;
            rd_len_in                = f_len;
            rsp_valid_in             = 1'b1;
            rsp_in                   = '0;
            rsp_in.status            = STATUS_OK;
            rsp_in.slot              = SLOTOUT_W'(read_slot_ff);
            rsp_in.mission_speed     = f_speed;
            rsp_in.mission_rate      = f_rate;
            rsp_in.mission_length    = LENOUT_W'(f_len);
            rsp_in.timer_period      = f_period;
            rsp_in.direction_compare = f_half;
            rsp_in.step_compare      = f_period - WORD_W'(pulse_ff);
            state_in                 = S_IDLE;
         end
         S_READ: begin
            rsp_valid_in     = 1'b1;
            rsp_in           = '0;
            rsp_in.status    = STATUS_OK;
            rsp_in.read_word = wm_rdata_ff;
            state_in         = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         write_slot_ff <= '0;
         read_slot_ff  <= '0;
         write_open_ff <= 1'b0;
         read_open_ff  <= 1'b0;
         wr_len_ff     <= '0;
         wr_speed_ff   <= '0;
         wr_rate_ff    <= '0;
         rd_len_ff     <= '0;
         last_x_ff     <= WORD_IDLE;
         last_y_ff     <= WORD_IDLE;
         period_ff     <= '0;
         half_ff       <= '0;
         pulse_ff      <= PULSE_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         write_slot_ff <= write_slot_in;
         read_slot_ff  <= read_slot_in;
         write_open_ff <= write_open_in;
         read_open_ff  <= read_open_in;
         wr_len_ff     <= wr_len_in;
         wr_speed_ff   <= wr_speed_in;
         wr_rate_ff    <= wr_rate_in;
         rd_len_ff     <= rd_len_in;
         last_x_ff     <= last_x_in;
         last_y_ff     <= last_y_in;
         period_ff     <= period_in;
         half_ff       <= half_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            pulse_ff <= csr_wdata;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pend_y_ff <= pend_y_in;
      rsp_ff    <= rsp_in;
   end

   // Mission word memory
   always_ff @(posedge clock) begin
      if (wm_we) begin
         word_mem[wm_waddr] <= wm_wdata;
      end
      wm_rdata_ff <= word_mem[wm_raddr];
   end

   // Slot descriptor memory: speed, rate, length
   always_ff @(posedge clock) begin
      if (mm_we) begin
         meta_mem[write_slot_ff] <= {wr_speed_ff, wr_rate_ff, wr_len_ff};
      end
      mm_rdata_ff <= meta_mem[rd_nx];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/stepper_mission_ring_queue.sv =====
// Stepper mission ring queue, top level.
// Requests (req_*) arrive on a valid/ready channel and go into a two-entry
// queue; the back end executes them one at a time and returns exactly one
// response (rsp_*) per request, in order, on a second valid/ready channel.
// Every response carries rsp_status (0 accepted, 1 rejected); rejected
// responses have all other fields zero.
// On its way to rsp_valid a request passes the queue entry and the result
// register; accepted fetch and read word add a registered memory read.
// Throughput: one request per cycle for open, append word, set speed/rate,
// close and complete unless the receiver stalls; append step (two writes
// on the one word memory port), accepted fetch and read word delay the next.
// csr_we/csr_wdata set the step pulse width (reset 10); write only when idle.
// Reset empties the ring, closes both sides and sets the last step words to
// the idle pattern; there is no memory clearing pass.
// When the receiver stalls, the response is held, the back end stops and the
// queue fills, after which req_ready falls.
// Depends on smrq_pkg, smrq_front, smrq_back and the assertion header.
`default_nettype none

module stepper_mission_ring_queue
   import smrq_pkg::*;
#(
   parameter int NUM_SLOTS  = 8,
   parameter int SLOT_WORDS = 256
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [PULSE_W-1:0]   csr_wdata,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [KIND_W-1:0]    req_kind,
   input  wire logic [WORD_W-1:0]    req_data_word,
   input  wire logic [STEP_W-1:0]    req_step_x,
   input  wire logic [STEP_W-1:0]    req_step_y,
   input  wire logic [SPEED_W-1:0]   req_speed_code,
   input  wire logic [RATE_W-1:0]    req_update_rate,
   input  wire logic [INDEX_W-1:0]   req_word_index,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_status,
   output logic [SLOTOUT_W-1:0]      rsp_slot,
   output logic [WORD_W-1:0]         rsp_read_word,
   output logic [SPEED_W-1:0]        rsp_mission_speed,
   output logic [RATE_W-1:0]         rsp_mission_rate,
   output logic [LENOUT_W-1:0]       rsp_mission_length,
   output logic [WORD_W-1:0]         rsp_timer_period,
   output logic [WORD_W-1:0]         rsp_direction_compare,
   output logic [WORD_W-1:0]         rsp_step_compare
);

   logic     q_valid;
   op_type   q_op;
   logic     q_take;
   rsp_type  rsp;

   // Accept and classify
   smrq_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_data_word   (req_data_word),
      .req_step_x      (req_step_x),
      .req_step_y      (req_step_y),
      .req_speed_code  (req_speed_code),
      .req_update_rate (req_update_rate),
      .req_word_index  (req_word_index),
      .q_valid         (q_valid),
      .q_op            (q_op),
      .q_take          (q_take)
   );

   // Execute
   smrq_back #(
      .NUM_SLOTS  (NUM_SLOTS),
      .SLOT_WORDS (SLOT_WORDS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .q_valid   (q_valid),
      .q_op      (q_op),
      .q_take    (q_take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   // Break the response out to ports
   assign rsp_status            = rsp.status;
   assign rsp_slot              = rsp.slot;
   assign rsp_read_word         = rsp.read_word;
   assign rsp_mission_speed     = rsp.mission_speed;
   assign rsp_mission_rate      = rsp.mission_rate;
   assign rsp_mission_length    = rsp.mission_length;
   assign rsp_timer_period      = rsp.timer_period;
   assign rsp_direction_compare = rsp.direction_compare;
   assign rsp_step_compare      = rsp.step_compare;

   // Checks
`include "stepper_mission_ring_queue_assert.svh"

   `SMRQ_ASSERT_IMP(a_take_needs_entry, q_take, q_valid, "back end popped an empty queue")
   `SMRQ_ASSERT_IMP(a_reject_clean, rsp_valid && rsp_status,
      rsp_slot == '0 && rsp_read_word == '0 && rsp_timer_period == '0 &&
      rsp_mission_length == '0 && rsp_step_compare == '0,
      "rejected response carries data")
   `SMRQ_ASSERT_IMP(a_half_period, rsp_valid && rsp_timer_period != '0,
      {rsp_direction_compare, 1'b0} == {1'b0, rsp_timer_period},
      "direction compare is not half the period")
   `SMRQ_ASSERT_NXT(a_full_stalls, q_valid && !q_take && !req_ready, q_valid,
      "queue lost an entry while stalled")

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the stepper mission ring queue (stepper_mission_ring_queue).
// Holds its own ring model to predict every response; needs smrq_pkg and the RTL only.
// A table of directed requests comes first, then random producer and consumer traffic.
module tb;
   import smrq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOT_DEPTH  = 256;
   localparam int ROUND_ITEMS = 370;
   localparam int STALL_LIMIT = 2000;

   // Kinds above KIND_DONE are illegal
   localparam logic [KIND_W-1:0]  KIND_ILLEGAL = 4'd15;
   localparam logic [STEP_W-1:0]  STEP_NONE    = 2'd0;
   localparam logic [STEP_W-1:0]  STEP_ODD     = 2'd3;
   localparam logic [SPEED_W-1:0] SPEED_10HZ   = 3'd0;
   localparam logic [SPEED_W-1:0] SPEED_1KHZ   = 3'd4;
   localparam logic [SPEED_W-1:0] SPEED_SPARE  = 3'd7;

   // Timer ticks per known speed
   localparam logic [WORD_W-1:0] TICKS_FULL [5] = '{16'd10000, 16'd5000, 16'd1000, 16'd500,
                                                    16'd100};
   localparam logic [WORD_W-1:0] TICKS_HALF [5] = '{16'd5000, 16'd2500, 16'd500, 16'd250,
                                                    16'd50};

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [WORD_W-1:0]  data_word;
      logic [STEP_W-1:0]  step_x;
      logic [STEP_W-1:0]  step_y;
      logic [SPEED_W-1:0] speed_code;
      logic [RATE_W-1:0]  update_rate;
      logic [INDEX_W-1:0] word_index;
   } req_t;

   // Directed row: the request, and a typed answer where one is given
   typedef struct packed {
      req_t                 r;
      logic                 typed;
      logic                 status;
      logic [SLOTOUT_W-1:0] slot;
   } dir_row_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [PULSE_W-1:0]   csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [KIND_W-1:0]    req_kind = '0;
   logic [WORD_W-1:0]    req_data_word = '0;
   logic [STEP_W-1:0]    req_step_x = '0;
   logic [STEP_W-1:0]    req_step_y = '0;
   logic [SPEED_W-1:0]   req_speed_code = '0;
   logic [RATE_W-1:0]    req_update_rate = '0;
   logic [INDEX_W-1:0]   req_word_index = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b1;
   logic                 rsp_status;
   logic [SLOTOUT_W-1:0] rsp_slot;
   logic [WORD_W-1:0]    rsp_read_word;
   logic [SPEED_W-1:0]   rsp_mission_speed;
   logic [RATE_W-1:0]    rsp_mission_rate;
   logic [LENOUT_W-1:0]  rsp_mission_length;
   logic [WORD_W-1:0]    rsp_timer_period;
   logic [WORD_W-1:0]    rsp_direction_compare;
   logic [WORD_W-1:0]    rsp_step_compare;

   // Ring model state
   logic [2:0]           wr_slot;
   logic [2:0]           rd_slot;
   logic                 wr_open;
   logic                 rd_open;
   logic [LENOUT_W-1:0]  mlen   [8];
   logic [SPEED_W-1:0]   mspeed [8];
   logic [RATE_W-1:0]    mrate  [8];
   logic [WORD_W-1:0]    mwords [8][SLOT_DEPTH];
   logic [WORD_W-1:0]    last_x;
   logic [WORD_W-1:0]    last_y;
   logic [WORD_W-1:0]    cur_period;
   logic [WORD_W-1:0]    cur_half;
   logic [PULSE_W-1:0]   pulse_width;

   rsp_type  awaited_rsp [$];
   dir_row_t dir_rows [$];
   int       errors = 0;
   int       rsp_count = 0;
   int       idle_cycles = 0;
   int       fill_goal = 0;
   int       producer_share = 50;
   bit       quiet = 1'b0;
   int       rsp_hold = 0;

   stepper_mission_ring_queue i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_we                (csr_we),
      .csr_wdata             (csr_wdata),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_kind              (req_kind),
      .req_data_word         (req_data_word),
      .req_step_x            (req_step_x),
      .req_step_y            (req_step_y),
      .req_speed_code        (req_speed_code),
      .req_update_rate       (req_update_rate),
      .req_word_index        (req_word_index),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_slot              (rsp_slot),
      .rsp_read_word         (rsp_read_word),
      .rsp_mission_speed     (rsp_mission_speed),
      .rsp_mission_rate      (rsp_mission_rate),
      .rsp_mission_length    (rsp_mission_length),
      .rsp_timer_period      (rsp_timer_period),
      .rsp_direction_compare (rsp_direction_compare),
      .rsp_step_compare      (rsp_step_compare)
   );

   always #5 clock = ~clock;

   // Capture-mode word for one axis; other codes keep the last high byte
   function automatic logic [WORD_W-1:0] step_word(input logic [STEP_W-1:0] code,
                                                   input logic [WORD_W-1:0] last);
      if (code == STEP_FWD) return WORD_FWD;
      if (code == STEP_BACK) return WORD_BACK;
      return (last & HIGH_MASK) | LOW_IDLE;
   endfunction

   function automatic void store_word(input logic [WORD_W-1:0] w);
      mwords[wr_slot][mlen[wr_slot][7:0]] = w;
      mlen[wr_slot] = mlen[wr_slot] + 1'b1;
   endfunction

   // Applies one request to the ring model and returns its response
   function automatic rsp_type ring_response(input req_t r);
      rsp_type          o;
      logic [2:0]       nx;
      logic [WORD_W-1:0] xw;
      logic [WORD_W-1:0] yw;
      o = '0;
      o.status = STATUS_REJ;
      case (r.kind)
         KIND_OPEN: begin
            nx = wr_slot + 3'd1;
            if (!wr_open && nx != rd_slot) begin
               wr_slot = nx;
               mlen[nx] = '0;
               mspeed[nx] = '0;
               mrate[nx] = '0;
               wr_open = 1'b1;
               o.slot = nx;
               o.status = STATUS_OK;
            end
         end
         KIND_WORD: begin
            if (wr_open && int'(mlen[wr_slot]) < SLOT_DEPTH) begin
               store_word(r.data_word);
               o.status = STATUS_OK;
            end
         end
         KIND_STEP: begin
            if (wr_open && int'(mlen[wr_slot]) + 2 <= SLOT_DEPTH) begin
               xw = step_word(r.step_x, last_x);
               yw = step_word(r.step_y, last_y);
               store_word(xw);
               store_word(yw);
               last_x = xw;
               last_y = yw;
               o.status = STATUS_OK;
            end
         end
         KIND_SPEED: begin
            if (wr_open) begin
               mspeed[wr_slot] = r.speed_code;
               o.status = STATUS_OK;
            end
         end
         KIND_RATE: begin
            if (wr_open) begin
               mrate[wr_slot] = r.update_rate;
               o.status = STATUS_OK;
            end
         end
         KIND_CLOSE: begin
            if (wr_open) begin
               wr_open = 1'b0;
               o.status = STATUS_OK;
            end
         end
         KIND_FETCH: begin
            nx = rd_slot + 3'd1;
            if (!rd_open && rd_slot != wr_slot && !(nx == wr_slot && wr_open)) begin
               rd_slot = nx;
               rd_open = 1'b1;
               // unknown speeds leave the timer values alone
               if (mspeed[nx] < NUM_SPEEDS) begin
                  cur_period = TICKS_FULL[mspeed[nx]];
                  cur_half = TICKS_HALF[mspeed[nx]];
               end
               o.slot = nx;
               o.mission_speed = mspeed[nx];
               o.mission_rate = mrate[nx];
               o.mission_length = mlen[nx];
               o.timer_period = cur_period;
               o.direction_compare = cur_half;
               o.step_compare = cur_period - {9'd0, pulse_width};
               o.status = STATUS_OK;
            end
         end
         KIND_READ: begin
            if (rd_open && {1'b0, r.word_index} < mlen[rd_slot]) begin
               o.read_word = mwords[rd_slot][r.word_index];
               o.status = STATUS_OK;
            end
         end
         KIND_DONE: begin
            if (rd_open) begin
               rd_open = 1'b0;
               o.status = STATUS_OK;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // Random request shaped by the model state: mostly well-formed missions
   task automatic pick_request(output req_t r);
      int len;
      r.kind = KIND_OPEN;
      r.data_word = WORD_W'($urandom);
      r.step_x = STEP_W'($urandom_range(0, 3));
      r.step_y = STEP_W'($urandom_range(0, 3));
      r.speed_code = ($urandom_range(0, 3) == 0) ? SPEED_W'($urandom_range(5, 7))
                                                  : SPEED_W'($urandom_range(0, 4));
      r.update_rate = RATE_W'($urandom_range(0, 255));
      r.word_index = INDEX_W'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) begin
         r.kind = KIND_W'($urandom_range(0, 15));
      end else if ($urandom_range(1, 100) <= producer_share) begin
         if (!wr_open) begin
            r.kind = KIND_OPEN;
            // now and then a mission filled to capacity and beyond
            fill_goal = ($urandom_range(0, 99) == 0) ? SLOT_DEPTH : $urandom_range(0, 12);
         end else if (int'(mlen[wr_slot]) >= fill_goal && $urandom_range(0, 1) == 0) begin
            r.kind = KIND_CLOSE;
         end else begin
            case ($urandom_range(0, 9))
               0:          r.kind = KIND_SPEED;
               1:          r.kind = KIND_RATE;
               2, 3, 4, 5: r.kind = KIND_WORD;
               default:    r.kind = KIND_STEP;
            endcase
         end
      end else begin
         if (!rd_open) begin
            r.kind = KIND_FETCH;
         end else if ($urandom_range(0, 3) == 0) begin
            r.kind = KIND_DONE;
         end else begin
            r.kind = KIND_READ;
            len = int'(mlen[rd_slot]);
            if (len > 0 && $urandom_range(0, 7) != 0)
               r.word_index = INDEX_W'($urandom_range(0, len - 1));
         end
      end
   endtask

   // Offers one request, waits for it to be taken and records its answer
   task automatic push_request(input req_t r, input logic typed, input logic status,
                               input logic [SLOTOUT_W-1:0] slot);
      int      gap;
      rsp_type want;
      gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 7) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_kind        <= r.kind;
      req_data_word   <= r.data_word;
      req_step_x      <= r.step_x;
      req_step_y      <= r.step_y;
      req_speed_code  <= r.speed_code;
      req_update_rate <= r.update_rate;
      req_word_index  <= r.word_index;
      req_valid       <= 1'b1;
      do @(posedge clock); while (!req_ready);
      want = ring_response(r);
      if (typed) begin
         want = '0;
         want.status = status;
         want.slot = slot;
      end
      awaited_rsp.push_back(want);
   endtask

   // Drops valid and waits until every response is back
   task automatic settle();
      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_pulse(input logic [PULSE_W-1:0] v);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      pulse_width = v;
      csr_we <= 1'b0;
   endtask

   task automatic add_row(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] data,
                          input logic [STEP_W-1:0] sx, input logic [STEP_W-1:0] sy,
                          input logic [SPEED_W-1:0] sp, input logic [RATE_W-1:0] rate,
                          input logic [INDEX_W-1:0] idx, input logic typed,
                          input logic status, input logic [SLOTOUT_W-1:0] slot);
      dir_row_t d;
      d.r = '{kind, data, sx, sy, sp, rate, idx};
      d.typed = typed;
      d.status = status;
      d.slot = slot;
      dir_rows.push_back(d);
   endtask

   task automatic report_mismatch(input string field, input logic [WORD_W-1:0] got,
                                  input logic [WORD_W-1:0] want);
      $display("tb: response %0d %s: got %h, want %h", rsp_count, field, got, want);
      errors++;
   endtask

   task automatic check_field(input string field, input logic [WORD_W-1:0] got,
                              input logic [WORD_W-1:0] want);
      if (got !== want) report_mismatch(field, got, want);
   endtask

   // Response checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_rsp.size() == 0) begin
            report_mismatch("unexpected response", {15'd0, rsp_status}, '0);
         end else begin
            want = awaited_rsp.pop_front();
            check_field("status", {15'd0, rsp_status}, {15'd0, want.status});
            check_field("slot", {13'd0, rsp_slot}, {13'd0, want.slot});
            check_field("read_word", rsp_read_word, want.read_word);
            check_field("mission_speed", {13'd0, rsp_mission_speed}, {13'd0, want.mission_speed});
            check_field("mission_rate", {8'd0, rsp_mission_rate}, {8'd0, want.mission_rate});
            check_field("mission_length", {7'd0, rsp_mission_length},
                        {7'd0, want.mission_length});
            check_field("timer_period", rsp_timer_period, want.timer_period);
            check_field("direction_compare", rsp_direction_compare, want.direction_compare);
            check_field("step_compare", rsp_step_compare, want.step_compare);
         end
         rsp_count++;
      end
   end

   // Receiver: drops ready in random bursts; always ready in reset and in quiet stretches
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_ready <= 1'b1;
         rsp_hold <= 0;
      end else if (rsp_hold != 0) begin
         rsp_ready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         rsp_hold <= $urandom_range(0, 6);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus
   initial begin
      req_t r;
      wr_slot = '0;
      rd_slot = '0;
      wr_open = 1'b0;
      rd_open = 1'b0;
      for (int s = 0; s < 8; s++) begin
         mlen[s] = '0;
         mspeed[s] = '0;
         mrate[s] = '0;
      end
      last_x = WORD_IDLE;
      last_y = WORD_IDLE;
      cur_period = '0;
      cur_half = '0;
      pulse_width = PULSE_RESET;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed table; typed rows: the rejections, the first open and plain accepts
      //      kind          data      x          y          speed        rate  idx  typ st          slot
      add_row(KIND_READ,    16'h0000, STEP_NONE, STEP_NONE, SPEED_10HZ,  8'd0, 8'd0, 1, STATUS_REJ, 0);
      add_row(KIND_FETCH,   16'h0000, STEP_NONE, STEP_NONE, SPEED_10HZ,  8'd0, 8'd0, 1, STATUS_REJ, 0);
      add_row(KIND_DONE,    16'h0000, STEP_NONE, STEP_NONE, SPEED_10HZ,  8'd0, 8'd0, 1, STATUS_REJ, 0);
      add_row(KIND_WORD,    16'hFFFF, STEP_NONE, STEP_NONE, SPEED_10HZ,  8'd0, 8'd0, 1, STATUS_REJ, 0);
      add_row(KIND_CLOSE,   16'h0000, STEP_NONE, STEP_NONE, SPEED_10HZ,  8'd0, 8'd0, 1, STATUS_REJ, 0);
      add_row(KIND_ILLEGAL, 16'hFFFF, STEP_ODD,  STEP_ODD,  SPEED_SPARE, 8'hFF, 8'hFF, 1, STATUS_REJ, 0);
      add_row(KIND_OPEN,    16'h0000, STEP_NONE, STEP_NONE, SPEED_10HZ,  8'd0, 8'd0, 1, STATUS_OK,  1);
      add_row(KIND_OPEN,    16'h0000, STEP_NONE, STEP_NONE, SPEED_10HZ,  8'd0, 8'd0, 1, STATUS_REJ, 0);
      add_row(KIND_WORD,    16'hFFFF, STEP_NONE, STEP_NONE, SPEED_10HZ,  8'd0, 8'd0, 1, STATUS_OK,  0);
      add_row(KIND_WORD,    16'h0000, STEP_NONE, STEP_NONE, SPEED_10HZ,  8'd0, 8'd0, 1, STATUS_OK,  0);
      add_row(KIND_STEP,    16'h0000, STEP_NONE, STEP_NONE, SPEED_10HZ,  8'd0, 8'd0, 1, STATUS_OK,  0);
      add_row(KIND_STEP,    16'h0000, STEP_FWD,  STEP_BACK, SPEED_10HZ,  8'd0, 8'd0, 1, STATUS_OK,  0);
      add_row(KIND_STEP,    16'h0000, STEP_NONE, STEP_NONE, SPEED_10HZ,  8'd0, 8'd0, 1, STATUS_OK,  0);
      add_row(KIND_STEP,    16'h0000, STEP_ODD,  STEP_FWD,  SPEED_10HZ,  8'd0, 8'd0, 1, STATUS_OK,  0);
      add_row(KIND_SPEED,   16'h0000, STEP_NONE, STEP_NONE, SPEED_SPARE, 8'd0, 8'd0, 1, STATUS_OK,  0);
      add_row(KIND_RATE,    16'h0000, STEP_NONE, STEP_NONE, SPEED_10HZ,  8'hFF, 8'd0, 1, STATUS_OK, 0);
      // the only mission is still open, so nothing to fetch yet
      add_row(KIND_FETCH,   16'h0000, STEP_NONE, STEP_NONE, SPEED_10HZ,  8'd0, 8'd0, 1, STATUS_REJ, 0);
      add_row(KIND_CLOSE,   16'h0000, STEP_NONE, STEP_NONE, SPEED_10HZ,  8'd0, 8'd0, 1, STATUS_OK,  0);
      // spare speed after reset: zero period, step compare wraps
      add_row(KIND_FETCH,   16'h0000, STEP_NONE, STEP_NONE, SPEED_10HZ,  8'd0, 8'd0, 0, STATUS_OK,  0);
      add_row(KIND_READ,    16'h0000, STEP_NONE, STEP_NONE, SPEED_10HZ,  8'd0, 8'd0, 0, STATUS_OK,  0);
      add_row(KIND_READ,    16'h0000, STEP_NONE, STEP_NONE, SPEED_10HZ,  8'd0, 8'd7, 0, STATUS_OK,  0);
      add_row(KIND_READ,    16'h0000, STEP_NONE, STEP_NONE, SPEED_10HZ,  8'd0, 8'd9, 0, STATUS_OK,  0);
      add_row(KIND_READ,    16'h0000, STEP_NONE, STEP_NONE, SPEED_10HZ,  8'd0, 8'd10, 1, STATUS_REJ, 0);
      add_row(KIND_READ,    16'h0000, STEP_NONE, STEP_NONE, SPEED_1KHZ,  8'd0, 8'hFF, 1, STATUS_REJ, 0);
      add_row(KIND_DONE,    16'h0000, STEP_NONE, STEP_NONE, SPEED_10HZ,  8'd0, 8'd0, 1, STATUS_OK,  0);
      add_row(KIND_FETCH,   16'h0000, STEP_NONE, STEP_NONE, SPEED_10HZ,  8'd0, 8'd0, 1, STATUS_REJ, 0);
      foreach (dir_rows[i])
         push_request(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].status, dir_rows[i].slot);

      // Random rounds, a new pulse width before each but the first; last round without idling
      for (int round = 0; round < 4; round++) begin
         if (round != 0) begin
            settle();
            case (round)
               1:       write_pulse(7'd0);
               2:       write_pulse(7'd100);
               default: write_pulse(PULSE_W'($urandom_range(0, 100)));
            endcase
         end
         for (int n = 0; n < ROUND_ITEMS; n++) begin
            if (n % 100 == 0) quiet = (round == 3) || ($urandom_range(0, 3) == 0);
            if (n % 60 == 0) begin
               case ($urandom_range(0, 2))
                  0:       producer_share = 15;
                  1:       producer_share = 50;
                  default: producer_share = 85;
               endcase
            end
            pick_request(r);
            push_request(r, 1'b0, STATUS_OK, '0);
         end
      end

      settle();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/smrq_pkg.sv
rtl/smrq_front.sv
rtl/smrq_back.sv
rtl/stepper_mission_ring_queue.sv
sim/tb.sv
